FILE: rtl/pending_request_tracker_macros.svh
// ----------------------------------------------------------------------------
// Pending request tracker assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PENDING_REQUEST_TRACKER_MACROS_SVH
`define PENDING_REQUEST_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Pending request tracker package
// Status codes, operation codes, table entry type and shared constants.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 8;
	localparam int unsigned MAX_OUT         = 8;
	localparam int unsigned NREM_W          = $clog2(MAX_OUT + 1);
	localparam logic [15:0] TIMEOUT_RESET   = 16'd500;
	localparam logic [15:0] ID_MASK         = 16'h7FFF;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_RESPONSE = 2'd1;
	localparam logic [1:0] OP_CHECK    = 2'd2;

	localparam logic [2:0] STAT_SUCCESS   = 3'd0;
	localparam logic [2:0] STAT_SEND_ERR  = 3'd1;
	localparam logic [2:0] STAT_NO_ROOM   = 3'd2;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [2:0] STAT_TIMED_OUT = 3'd4;
	localparam logic [2:0] STAT_RESEND    = 3'd5;

	localparam logic ADDR_TIMEOUT = 1'b0;

	typedef struct packed {
		logic [14:0] id;
		logic [7:0]  sequence_num;
		logic [31:0] sent_time;
		logic        handler;
		logic        retry;
	} entry_t;

	// table update commands from the sequencer
	typedef struct packed {
		logic append;
		logic remove;
	} tbl_ctrl_t;

	// compare unit verdicts
	typedef struct packed {
		logic match;
		logic expired;
	} cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/pending_request_tracker.sv
// Register item: busy stays low; its result strobes in the next cycle.
// Response item: busy while entries are compared in table order up to the first match, and
// for a final step when none matches; the result strobes in the same cycle busy falls.
// Check item: busy until the table is scanned or eight entries are removed; each expired
// result is held until the next one or the end; at most eight are sent, the last as busy falls.
// Results cannot be stalled. Reset clears occupancy, sequencer, timeout_ms to 500, not payload.
// ----------------------------------------------------------------------------
// Pending request tracker
// Outstanding request table with response matching and timeout sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_request_tracker #(
	parameter int unsigned TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command side
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] msg_id,
	input  wire logic [7:0]  sequence_req,
	input  wire logic        has_handler,
	input  wire logic        want_retry,
	input  wire logic        send_ok,
	input  wire logic [31:0] now_ms,
	// result side
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [14:0]      result_id,
	output logic [7:0]       result_sequence,
	output logic             entry_handler,
	output logic             last,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import prt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic {ST_IDLE, ST_SCAN} state_t;

	state_t              state_q;
	logic                is_check_q;
	logic [14:0]         key_id_q;
	logic [7:0]          key_seq_q;
	logic [31:0]         now_q;
	logic [CNT_W-1:0]    idx_q;
	logic [NREM_W-1:0]   nrem_q;
	logic [15:0]         timeout_q;

	// held check result, sent once the next one or the end is known
	logic                pend_valid_q;
	logic [2:0]          pend_status_q;
	logic [14:0]         pend_id_q;
	logic [7:0]          pend_seq_q;
	logic                pend_handler_q;

	logic                rv_q;
	logic [2:0]          status_q;
	logic [14:0]         rid_q;
	logic [7:0]          rseq_q;
	logic                rhandler_q;
	logic                last_q;

	tbl_ctrl_t           tctrl;
	entry_t              new_entry;
	entry_t              cur_entry;
	cmp_res_t            cmp;
	logic [CNT_W-1:0]    occ;
	logic [IDX_W-1:0]    tidx;
	logic                accept;
	logic                in_range;
	logic                cap_hit;
	logic                wants_store;

	// ---------------- configuration ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == ADDR_TIMEOUT)) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// ---------------- table and compare unit ----------------
	assign accept      = start && (state_q == ST_IDLE);
	assign wants_store = has_handler || want_retry;
	assign in_range    = idx_q < occ;
	assign cap_hit     = nrem_q == NREM_W'(MAX_OUT);
	assign tidx        = idx_q[IDX_W-1:0];

	assign new_entry.id           = msg_id[14:0];
	assign new_entry.sequence_num = sequence_req;
	assign new_entry.sent_time    = now_ms;
	assign new_entry.handler      = has_handler;
	assign new_entry.retry        = want_retry;

	always_comb begin
		tctrl.append = accept && (operation == OP_REGISTER) && send_ok && wants_store
			&& (occ < CNT_W'(TABLE_DEPTH));
		tctrl.remove = 1'b0;
		if (state_q == ST_SCAN && in_range) begin
			if (is_check_q) begin
				tctrl.remove = !cap_hit && cmp.expired;
			end else begin
				tctrl.remove = cmp.match;
			end
		end
	end

	prt_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (tctrl),
		.append_entry (new_entry),
		.idx          (tidx),
		.rd_entry     (cur_entry),
		.occupancy    (occ)
	);

	prt_cmp_unit u_cmp (
		.entry   (cur_entry),
		.key_id  (key_id_q),
		.key_seq (key_seq_q),
		.now     (now_q),
		.timeout (timeout_q),
		.res     (cmp)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			is_check_q     <= 1'b0;
			key_id_q       <= '0;
			key_seq_q      <= '0;
			now_q          <= '0;
			idx_q          <= '0;
			nrem_q         <= '0;
			pend_valid_q   <= 1'b0;
			pend_status_q  <= STAT_SUCCESS;
			pend_id_q      <= '0;
			pend_seq_q     <= '0;
			pend_handler_q <= 1'b0;
			rv_q           <= 1'b0;
			status_q       <= STAT_SUCCESS;
			rid_q          <= '0;
			rseq_q         <= '0;
			rhandler_q     <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_id_q     <= msg_id[14:0];
						key_seq_q    <= sequence_req;
						now_q        <= now_ms;
						idx_q        <= '0;
						nrem_q       <= '0;
						pend_valid_q <= 1'b0;
						is_check_q   <= operation == OP_CHECK;
						case (operation)
							OP_REGISTER: begin
								rv_q       <= 1'b1;
								rid_q      <= msg_id[14:0];
								rseq_q     <= sequence_req;
								rhandler_q <= 1'b0;
								last_q     <= 1'b1;
								if (!send_ok) begin
									status_q <= STAT_SEND_ERR;
								end else if (wants_store && (occ >= CNT_W'(TABLE_DEPTH))) begin
									status_q <= STAT_NO_ROOM;
								end else begin
									status_q <= STAT_SUCCESS;
								end
							end
							OP_RESPONSE, OP_CHECK: begin
								state_q <= ST_SCAN;
							end
							default: begin
								// unused code: dropped without a transaction
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (!is_check_q) begin
						if (!in_range) begin
							rv_q       <= 1'b1;
							status_q   <= STAT_NOT_FOUND;
							rid_q      <= key_id_q;
							rseq_q     <= key_seq_q;
							rhandler_q <= 1'b0;
							last_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else if (cmp.match) begin
							rv_q       <= 1'b1;
							status_q   <= STAT_SUCCESS;
							rid_q      <= cur_entry.id;
							rseq_q     <= cur_entry.sequence_num;
							rhandler_q <= cur_entry.handler;
							last_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end else begin
						if (!in_range || cap_hit) begin
							rv_q         <= pend_valid_q;
							status_q     <= pend_status_q;
							rid_q        <= pend_id_q;
							rseq_q       <= pend_seq_q;
							rhandler_q   <= pend_handler_q;
							last_q       <= 1'b1;
							pend_valid_q <= 1'b0;
							state_q      <= ST_IDLE;
						end else if (cmp.expired) begin
							// removal compacts the table, so idx stays put
							rv_q           <= pend_valid_q;
							status_q       <= pend_status_q;
							rid_q          <= pend_id_q;
							rseq_q         <= pend_seq_q;
							rhandler_q     <= pend_handler_q;
							last_q         <= 1'b0;
							pend_valid_q   <= 1'b1;
							pend_status_q  <= cur_entry.retry ? STAT_RESEND : STAT_TIMED_OUT;
							pend_id_q      <= cur_entry.id;
							pend_seq_q     <= cur_entry.sequence_num;
							pend_handler_q <= cur_entry.handler;
							nrem_q         <= nrem_q + NREM_W'(1);
						end else begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy            = state_q != ST_IDLE;
	assign result_valid    = rv_q;
	assign status          = status_q;
	assign result_id       = rid_q;
	assign result_sequence = rseq_q;
	assign entry_handler   = rhandler_q;
	assign last            = last_q;

endmodule

`default_nettype wire

FILE: rtl/prt_cmp_unit.sv
// ----------------------------------------------------------------------------
// Pending request tracker compare unit
// Shared key match and wrap-around elapsed time check for one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_cmp_unit (
	input  wire prt_pkg::entry_t   entry,
	input  wire logic [14:0]       key_id,
	input  wire logic [7:0]        key_seq,
	input  wire logic [31:0]       now,
	input  wire logic [15:0]       timeout,
	output prt_pkg::cmp_res_t      res
);
	import prt_pkg::*;

	logic [31:0] elapsed;

	// modulo 2^32 subtraction handles tick wrap
	assign elapsed     = now - entry.sent_time;
	assign res.expired = elapsed > {16'd0, timeout};
	assign res.match   = (entry.id == key_id) && (entry.sequence_num == key_seq);

endmodule

`default_nettype wire

FILE: rtl/prt_table.sv
// ----------------------------------------------------------------------------
// Pending request tracker table
// Insertion-ordered entry store with append, compacting remove and one read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_table #(
	parameter int unsigned DEPTH = prt_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire prt_pkg::tbl_ctrl_t ctrl,
	input  wire prt_pkg::entry_t    append_entry,
	input  wire logic [IDX_W-1:0]   idx,
	output prt_pkg::entry_t         rd_entry,
	output logic [CNT_W-1:0]        occupancy
);
	import prt_pkg::*;

	entry_t            slot_q [DEPTH];
	logic [CNT_W-1:0]  occ_q;

	assign occupancy = occ_q;
	assign rd_entry  = slot_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.append) begin
			occ_q <= occ_q + CNT_W'(1);
		end else if (ctrl.remove) begin
			occ_q <= occ_q - CNT_W'(1);
		end
	end

	// entry payload carries no reset; slots past occupancy are never read
	always_ff @(posedge clk) begin
		if (ctrl.append) begin
			slot_q[occ_q[IDX_W-1:0]] <= append_entry;
		end else if (ctrl.remove) begin
			for (int i = 0; i < int'(DEPTH) - 1; i++) begin
				if (IDX_W'(i) >= idx) begin
					slot_q[i] <= slot_q[i+1];
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/prt_checker.sv
// ----------------------------------------------------------------------------
// Pending request tracker port checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pending_request_tracker_macros.svh"

module prt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  operation,
	input wire logic        send_ok,
	input wire logic        result_valid,
	input wire logic [2:0]  status,
	input wire logic        entry_handler,
	input wire logic        last
);
	import prt_pkg::*;

	`PRT_ASSERT_NEXT(a_reg_result, clk, arst_n, start && !busy && operation == OP_REGISTER, result_valid && last && !entry_handler, "register transaction must give one result next cycle")

	`PRT_ASSERT_NEXT(a_reg_senderr, clk, arst_n, start && !busy && operation == OP_REGISTER && !send_ok, status == STAT_SEND_ERR, "failed send must report send error")

	`PRT_ASSERT_NEXT(a_scan_busy, clk, arst_n, start && !busy && (operation == OP_RESPONSE || operation == OP_CHECK), busy, "response or check transaction must occupy the sequencer")

	`PRT_ASSERT_NOW(a_single_status, clk, arst_n, result_valid && (status == STAT_SEND_ERR || status == STAT_NO_ROOM || status == STAT_NOT_FOUND), last, "single-result status must be last")

	`PRT_ASSERT_NOW(a_status_range, clk, arst_n, result_valid, status == STAT_SUCCESS || status == STAT_SEND_ERR || status == STAT_NO_ROOM || status == STAT_NOT_FOUND || status == STAT_TIMED_OUT || status == STAT_RESEND, "status code out of range")

endmodule

bind pending_request_tracker prt_checker u_prt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.operation     (operation),
	.send_ok       (send_ok),
	.result_valid  (result_valid),
	.status        (status),
	.entry_handler (entry_handler),
	.last          (last)
);

`default_nettype wire
